[rtl/core/dcm_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the drive command mixer.
`default_nettype none

package dcm_pkg;

   // Full-scale drive value and full-stick value
   localparam int PWM_FULL   = 255;
   localparam int STICK_FULL = 1000;

   // Largest magnitude an applied drive value may take
   localparam int OUT_MAX = 255;

   // Field widths
   localparam int ACTION_W = 3;
   localparam int SEQ_W    = 16;
   localparam int WHEEL_W  = 9;
   localparam int STICK_W  = 11;
   localparam int AUX_W    = 2;
   localparam int LEVEL_W  = 8;
   localparam int COUNT_W  = 32;

   // Mixed sum width and the widths of the scaling divider
   localparam int MIX_W   = STICK_W + 1;
   localparam int SF_W    = $clog2(STICK_FULL + 1);
   localparam int PEAK_W  = (MIX_W > SF_W) ? MIX_W : SF_W;
   localparam int PWM_W   = $clog2(PWM_FULL + 1);
   localparam int NUM_W   = PEAK_W + PWM_W;
   localparam int STEP_W  = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   // Command codes
   localparam logic [ACTION_W-1:0] ACT_WHEELS    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_JOYSTICK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_KEEPALIVE = 3'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic mix;       // form the arcade mix, magnitudes and peak
      logic scale;     // multiply the magnitudes by full scale
      logic step;      // one restoring division step in both lanes
      logic commit;    // update applied state and result fields
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic joystick;  // incoming item is a joystick command
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/dcm_ctrl.sv]
// Sequencer for the drive command mixer: handshakes, divider step count and commit.
`default_nettype none

module dcm_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   input  wire dcm_pkg::dp_status_type status,
   output dcm_pkg::dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_SCALE,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   state_type                     state_ff;
   logic [dcm_pkg::STEP_W-1:0]    step_ff;
   logic                          rsp_valid_ff;
   logic                          slot_free;
   logic                          accept;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      cmd.mix     = (state_ff == ST_MIX);
      cmd.scale   = (state_ff == ST_SCALE);
      cmd.step    = (state_ff == ST_DIVIDE);
      cmd.commit  = (state_ff == ST_COMMIT) && slot_free;
   end

   // Advance the sequence and hold the result valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= status.joystick ? ST_MIX : ST_COMMIT;
               end
            end
            ST_MIX: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               step_ff  <= dcm_pkg::STEP_W'(dcm_pkg::NUM_W - 1);
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/dcm_datapath.sv]
// Datapath of the drive command mixer: item latch, arcade mix, two-lane divider, applied state.
`default_nettype none

module dcm_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire dcm_pkg::dp_cmd_type             cmd,
   output dcm_pkg::dp_status_type               status,
   input  wire        [dcm_pkg::ACTION_W-1:0]   req_action,
   input  wire        [dcm_pkg::SEQ_W-1:0]      req_seq_number,
   input  wire signed [dcm_pkg::WHEEL_W-1:0]    req_wheel_left,
   input  wire signed [dcm_pkg::WHEEL_W-1:0]    req_wheel_right,
   input  wire signed [dcm_pkg::STICK_W-1:0]    req_stick_x,
   input  wire signed [dcm_pkg::STICK_W-1:0]    req_stick_y,
   input  wire        [dcm_pkg::AUX_W-1:0]      req_aux_present,
   input  wire signed [dcm_pkg::WHEEL_W-1:0]    req_actuator_in,
   input  wire        [dcm_pkg::LEVEL_W-1:0]    req_brush_in,
   input  wire        [dcm_pkg::LEVEL_W-1:0]    req_light_in,
   output logic                                 rsp_understood,
   output logic       [dcm_pkg::SEQ_W-1:0]      rsp_seq_echo,
   output logic signed [dcm_pkg::WHEEL_W-1:0]   rsp_left_drive,
   output logic signed [dcm_pkg::WHEEL_W-1:0]   rsp_right_drive,
   output logic signed [dcm_pkg::WHEEL_W-1:0]   rsp_actuator_out,
   output logic       [dcm_pkg::LEVEL_W-1:0]    rsp_brush_out,
   output logic       [dcm_pkg::LEVEL_W-1:0]    rsp_light_out,
   output logic       [dcm_pkg::COUNT_W-1:0]    rsp_packet_count,
   output logic                                 rsp_link_up
);

   localparam int MIX_W  = dcm_pkg::MIX_W;
   localparam int PEAK_W = dcm_pkg::PEAK_W;
   localparam int NUM_W  = dcm_pkg::NUM_W;
   localparam int WW     = dcm_pkg::WHEEL_W;
   localparam int LW     = dcm_pkg::LEVEL_W;

   // Latched item
   logic [dcm_pkg::ACTION_W-1:0] action_ff;
   logic [dcm_pkg::SEQ_W-1:0]    seq_ff;
   logic [WW-1:0]                wheel_left_ff;
   logic [WW-1:0]                wheel_right_ff;
   logic [dcm_pkg::STICK_W-1:0]  stick_x_ff;
   logic [dcm_pkg::STICK_W-1:0]  stick_y_ff;
   logic [dcm_pkg::AUX_W-1:0]    aux_ff;
   logic [WW-1:0]                actuator_ff;
   logic [LW-1:0]                brush_ff;
   logic [LW-1:0]                light_ff;

   // Mix and divider lanes
   logic [MIX_W-1:0]  mix_l;
   logic [MIX_W-1:0]  mix_r;
   logic [PEAK_W-1:0] mag_l;
   logic [PEAK_W-1:0] mag_r;
   logic [PEAK_W-1:0] peak_max;
   logic              neg_l_ff;
   logic              neg_r_ff;
   logic [PEAK_W-1:0] mag_l_ff;
   logic [PEAK_W-1:0] mag_r_ff;
   logic [PEAK_W-1:0] peak_ff;
   logic [NUM_W-1:0]  num_l_ff;
   logic [NUM_W-1:0]  num_r_ff;
   logic [PEAK_W-1:0] rem_l_ff;
   logic [PEAK_W-1:0] rem_r_ff;
   logic [PEAK_W:0]   part_l;
   logic [PEAK_W:0]   part_r;
   logic              qbit_l;
   logic              qbit_r;
   logic [PEAK_W-1:0] rem_l_in;
   logic [PEAK_W-1:0] rem_r_in;
   logic [WW-1:0]     drive_l;
   logic [WW-1:0]     drive_r;

   // Applied state
   logic                         known;
   logic                         understood_ff;
   logic [dcm_pkg::SEQ_W-1:0]    last_seq_ff;
   logic [WW-1:0]                left_ff;
   logic [WW-1:0]                right_ff;
   logic [WW-1:0]                act_out_ff;
   logic [LW-1:0]                brush_out_ff;
   logic [LW-1:0]                light_out_ff;
   logic [dcm_pkg::COUNT_W-1:0]  count_ff;
   logic                         link_ff;

   // Saturate a quotient and apply the sign of its lane
   function automatic logic [WW-1:0] signed_drive(input logic [NUM_W-1:0] q,
                                                  input logic neg);
      logic [WW-1:0] mag;
      if (q > NUM_W'(dcm_pkg::OUT_MAX)) begin
         mag = WW'(dcm_pkg::OUT_MAX);
      end else begin
         mag = WW'(q);
      end
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   assign status.joystick = (req_action == dcm_pkg::ACT_JOYSTICK);

   // Arcade mix: l = y + x, r = y - x, and peak = max(full stick, |l|, |r|)
   always_comb begin
      mix_l = {stick_y_ff[dcm_pkg::STICK_W-1], stick_y_ff}
            + {stick_x_ff[dcm_pkg::STICK_W-1], stick_x_ff};
      mix_r = {stick_y_ff[dcm_pkg::STICK_W-1], stick_y_ff}
            - {stick_x_ff[dcm_pkg::STICK_W-1], stick_x_ff};
      mag_l = PEAK_W'(mix_l[MIX_W-1] ? (~mix_l + 1'b1) : mix_l);
      mag_r = PEAK_W'(mix_r[MIX_W-1] ? (~mix_r + 1'b1) : mix_r);
      peak_max = PEAK_W'(dcm_pkg::STICK_FULL);
      if (mag_l > peak_max) begin
         peak_max = mag_l;
      end
      if (mag_r > peak_max) begin
         peak_max = mag_r;
      end
   end

   // One restoring step in each lane against the shared peak
   always_comb begin
      part_l = {rem_l_ff, num_l_ff[NUM_W-1]};
      part_r = {rem_r_ff, num_r_ff[NUM_W-1]};
      qbit_l = (part_l >= {1'b0, peak_ff});
      qbit_r = (part_r >= {1'b0, peak_ff});
      rem_l_in = qbit_l ? PEAK_W'(part_l - {1'b0, peak_ff}) : PEAK_W'(part_l);
      rem_r_in = qbit_r ? PEAK_W'(part_r - {1'b0, peak_ff}) : PEAK_W'(part_r);
      drive_l = signed_drive(num_l_ff, neg_l_ff);
      drive_r = signed_drive(num_r_ff, neg_r_ff);
   end

   // Latch the item and run the mix, scale and divide steps
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff      <= req_action;
         seq_ff         <= req_seq_number;
         wheel_left_ff  <= req_wheel_left;
         wheel_right_ff <= req_wheel_right;
         stick_x_ff     <= req_stick_x;
         stick_y_ff     <= req_stick_y;
         aux_ff         <= req_aux_present;
         actuator_ff    <= req_actuator_in;
         brush_ff       <= req_brush_in;
         light_ff       <= req_light_in;
      end
      if (cmd.mix) begin
         neg_l_ff <= mix_l[MIX_W-1];
         neg_r_ff <= mix_r[MIX_W-1];
         mag_l_ff <= mag_l;
         mag_r_ff <= mag_r;
         peak_ff  <= peak_max;
      end
      if (cmd.scale) begin
         num_l_ff <= NUM_W'(mag_l_ff) * NUM_W'(dcm_pkg::PWM_FULL);
         num_r_ff <= NUM_W'(mag_r_ff) * NUM_W'(dcm_pkg::PWM_FULL);
         rem_l_ff <= '0;
         rem_r_ff <= '0;
      end else if (cmd.step) begin
         num_l_ff <= {num_l_ff[NUM_W-2:0], qbit_l};
         num_r_ff <= {num_r_ff[NUM_W-2:0], qbit_r};
         rem_l_ff <= rem_l_in;
         rem_r_ff <= rem_r_in;
      end
   end

   // Only wheels, joystick, stop and keepalive are understood
   assign known = action_ff inside {dcm_pkg::ACT_WHEELS, dcm_pkg::ACT_JOYSTICK,
                                    dcm_pkg::ACT_STOP, dcm_pkg::ACT_KEEPALIVE};

   // Apply the command to the drive state and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         understood_ff <= 1'b0;
         last_seq_ff   <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         act_out_ff    <= '0;
         brush_out_ff  <= '0;
         light_out_ff  <= '0;
         count_ff      <= '0;
         link_ff       <= 1'b0;
      end else if (cmd.commit) begin
         understood_ff <= known;
         if (known) begin
            last_seq_ff <= seq_ff;
            count_ff    <= count_ff + 1'b1;
            link_ff     <= 1'b1;
         end
         unique case (action_ff)
            dcm_pkg::ACT_WHEELS: begin
               left_ff      <= wheel_left_ff;
               right_ff     <= wheel_right_ff;
               act_out_ff   <= (aux_ff >= 2'd1) ? actuator_ff : '0;
               brush_out_ff <= (aux_ff >= 2'd2) ? brush_ff : '0;
               light_out_ff <= (aux_ff >= 2'd3) ? light_ff : '0;
            end
            dcm_pkg::ACT_JOYSTICK: begin
               left_ff      <= drive_l;
               right_ff     <= drive_r;
               act_out_ff   <= '0;
               brush_out_ff <= '0;
               light_out_ff <= '0;
            end
            dcm_pkg::ACT_STOP: begin
               left_ff      <= '0;
               right_ff     <= '0;
               act_out_ff   <= '0;
               brush_out_ff <= '0;
               light_out_ff <= '0;
            end
            dcm_pkg::ACT_KEEPALIVE: begin
            end
            default: begin
               // not understood: keep all state, report it unchanged
            end
         endcase
      end
   end

   assign rsp_understood   = understood_ff;
   assign rsp_seq_echo     = last_seq_ff;
   assign rsp_left_drive   = left_ff;
   assign rsp_right_drive  = right_ff;
   assign rsp_actuator_out = act_out_ff;
   assign rsp_brush_out    = brush_out_ff;
   assign rsp_light_out    = light_out_ff;
   assign rsp_packet_count = count_ff;
   assign rsp_link_up      = link_ff;

endmodule

`default_nettype wire

[rtl/core/drive_command_mixer_unit.sv]
// Top level of the drive command mixer: sequencer plus datapath.
`default_nettype none

// Takes one parsed drive command per item and returns one result item with the
// applied drive state. Wheels, stop, keepalive and unrecognized commands go
// from acceptance through the latch, then the commit, to the result. A joystick
// command goes through the latch, the forming of the arcade mix and peak, the
// multiply by full scale, 20 restoring division steps (both wheels divided
// side by side against the shared peak), then the commit. A new item is taken
// only while the sequencer is idle; the result register lets the next command
// start while an earlier result still waits to be taken, and a commit waits
// for that register to free up. The result fields always show the applied
// state, so they hold steady while the result is stalled.

module drive_command_mixer_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire        [dcm_pkg::ACTION_W-1:0]    req_action,
   input  wire        [dcm_pkg::SEQ_W-1:0]       req_seq_number,
   input  wire signed [dcm_pkg::WHEEL_W-1:0]     req_wheel_left,
   input  wire signed [dcm_pkg::WHEEL_W-1:0]     req_wheel_right,
   input  wire signed [dcm_pkg::STICK_W-1:0]     req_stick_x,
   input  wire signed [dcm_pkg::STICK_W-1:0]     req_stick_y,
   input  wire        [dcm_pkg::AUX_W-1:0]       req_aux_present,
   input  wire signed [dcm_pkg::WHEEL_W-1:0]     req_actuator_in,
   input  wire        [dcm_pkg::LEVEL_W-1:0]     req_brush_in,
   input  wire        [dcm_pkg::LEVEL_W-1:0]     req_light_in,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_understood,
   output logic       [dcm_pkg::SEQ_W-1:0]       rsp_seq_echo,
   output logic signed [dcm_pkg::WHEEL_W-1:0]    rsp_left_drive,
   output logic signed [dcm_pkg::WHEEL_W-1:0]    rsp_right_drive,
   output logic signed [dcm_pkg::WHEEL_W-1:0]    rsp_actuator_out,
   output logic       [dcm_pkg::LEVEL_W-1:0]     rsp_brush_out,
   output logic       [dcm_pkg::LEVEL_W-1:0]     rsp_light_out,
   output logic       [dcm_pkg::COUNT_W-1:0]     rsp_packet_count,
   output logic                                  rsp_link_up
);

   dcm_pkg::dp_cmd_type    cmd;
   dcm_pkg::dp_status_type status;

   dcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dcm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_seq_number   (req_seq_number),
      .req_wheel_left   (req_wheel_left),
      .req_wheel_right  (req_wheel_right),
      .req_stick_x      (req_stick_x),
      .req_stick_y      (req_stick_y),
      .req_aux_present  (req_aux_present),
      .req_actuator_in  (req_actuator_in),
      .req_brush_in     (req_brush_in),
      .req_light_in     (req_light_in),
      .rsp_understood   (rsp_understood),
      .rsp_seq_echo     (rsp_seq_echo),
      .rsp_left_drive   (rsp_left_drive),
      .rsp_right_drive  (rsp_right_drive),
      .rsp_actuator_out (rsp_actuator_out),
      .rsp_brush_out    (rsp_brush_out),
      .rsp_light_out    (rsp_light_out),
      .rsp_packet_count (rsp_packet_count),
      .rsp_link_up      (rsp_link_up)
   );

endmodule

`default_nettype wire
